// ----- sv/mkl_pkg.sv -----
// Package for the MRU key list: sizes, request codes, cell controls and state types.
// Used by mkl_cell, mkl_ctrl and mru_key_list; depends on nothing else.

package mkl_pkg;

   localparam int DEPTH    = 16;
   localparam int KEY_BITS = 32;
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam int CAP_BITS = 5;

   typedef logic [KEY_BITS-1:0] key_type;
   typedef logic [CNT_BITS-1:0] cnt_type;

   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_CLEAR  = 2'd2,
      MODE_LIST   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE,
      CELL_ROTATE
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      key_type     key;
   } cell_ctl_type;

   typedef enum logic {
      ST_IDLE,
      ST_LIST
   } state_type;

   // A capacity of zero keeps one entry; anything above the cell count keeps all.
   function automatic cnt_type eff_cap(logic [CAP_BITS-1:0] value);
      cnt_type result;
      if (value == '0) begin
         result = cnt_type'(1);
      end else if (32'(value) > DEPTH) begin
         result = cnt_type'(DEPTH);
      end else begin
         result = cnt_type'(value);
      end
      return result;
   endfunction

endpackage

// ----- sv/mkl_cell.sv -----
// One storage cell of the MRU key list chain: holds a key and compares it.
// Depends on mkl_pkg.

module mkl_cell
   import mkl_pkg::*;
(
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  logic         occupied,
   input  logic         tail,
   input  key_type      left_key,
   input  key_type      right_key,
   input  key_type      wrap_key,
   input  logic         hit_in,
   output logic         hit_out,
   output key_type      key_q
);

   key_type key_ff;
   key_type key_in;
   logic    match;

   assign match   = occupied && (key_ff == ctl.key);
   assign hit_out = hit_in | match;
   assign key_q   = key_ff;

   // Insert shifts everything ahead of the old copy one place back; remove
   // closes the gap behind the matching cell; rotate walks the list forward.
   always_comb begin
      key_in = key_ff;
      case (ctl.op)
         CELL_INSERT: begin
            if (!hit_in) begin
               key_in = left_key;
            end
         end
         CELL_REMOVE: begin
            if (hit_out) begin
               key_in = right_key;
            end
         end
         CELL_ROTATE: begin
            key_in = tail ? wrap_key : right_key;
         end
         default: begin
            key_in = key_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule

// ----- sv/mkl_ctrl.sv -----
// Sequencer of the MRU key list: request decode, entry count, capacity and result register.
// Depends on mkl_pkg; drives the cell chain of mru_key_list.

module mkl_ctrl
   import mkl_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [1:0]          req_tuser,
   input  key_type             req_key,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output key_type             rsp_key,
   output logic                rsp_tlast,
   output logic                rsp_empty,
   output logic                rsp_present,
   input  logic                csr_wr_en,
   input  logic [CAP_BITS-1:0] csr_wr_data,
   input  logic                found,
   input  key_type             head_key,
   output cell_ctl_type        cell_ctl,
   output cnt_type             count
);

   state_type           state_ff, state_in;
   cnt_type             count_ff, count_in;
   cnt_type             left_ff, left_in;
   logic [CAP_BITS-1:0] cap_ff, cap_in;
   logic                rsp_valid_ff, rsp_valid_in;
   key_type             rsp_key_ff, rsp_key_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                rsp_empty_ff, rsp_empty_in;
   logic                rsp_present_ff, rsp_present_in;

   logic     out_free;
   logic     accept;
   logic     load;
   mode_type mode;
   cnt_type  cap_eff;
   cnt_type  kept;
   cnt_type  cap_new;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;
   assign mode       = mode_type'(req_tuser);
   assign cap_eff    = eff_cap(cap_ff);
   assign cap_new    = eff_cap(csr_wr_data);
   assign kept       = count_ff - cnt_type'(found);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && mode == MODE_LIST && count_ff != '0) begin
               state_in = ST_LIST;
            end
         end
         ST_LIST: begin
            if (out_free && left_ff == cnt_type'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cell_ctl.op    = CELL_HOLD;
      cell_ctl.key   = req_key;
      count_in       = count_ff;
      left_in        = left_ff;
      cap_in         = cap_ff;
      load           = 1'b0;
      rsp_key_in     = rsp_key_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_empty_in   = rsp_empty_ff;
      rsp_present_in = rsp_present_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               load           = 1'b1;
               rsp_key_in     = '0;
               rsp_last_in    = 1'b1;
               rsp_empty_in   = 1'b0;
               rsp_present_in = 1'b0;
               case (mode)
                  MODE_INSERT: begin
                     cell_ctl.op    = CELL_INSERT;
                     rsp_present_in = found;
                     count_in       = ((kept >= cap_eff) ? cap_eff - cnt_type'(1) : kept)
                                      + cnt_type'(1);
                  end
                  MODE_REMOVE: begin
                     cell_ctl.op    = CELL_REMOVE;
                     rsp_present_in = found;
                     count_in       = kept;
                  end
                  MODE_CLEAR: begin
                     count_in = '0;
                  end
                  MODE_LIST: begin
                     if (count_ff == '0) begin
                        rsp_empty_in = 1'b1;
                     end else begin
                        load    = 1'b0;
                        left_in = count_ff;
                     end
                  end
                  default: begin
                     count_in = count_ff;
                  end
               endcase
            end
         end
         ST_LIST: begin
            if (out_free) begin
               cell_ctl.op    = CELL_ROTATE;
               load           = 1'b1;
               rsp_key_in     = head_key;
               rsp_last_in    = (left_ff == cnt_type'(1));
               rsp_empty_in   = 1'b0;
               rsp_present_in = 1'b0;
               left_in        = left_ff - cnt_type'(1);
            end
         end
         default: begin
            load = 1'b0;
         end
      endcase
      // Write capacity only while idle (not checked); a lower one drops oldest entries.
      if (csr_wr_en) begin
         cap_in = csr_wr_data;
         if (count_ff > cap_new) begin
            count_in = cap_new;
         end
      end
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         left_ff      <= '0;
         cap_ff       <= CAP_BITS'(DEPTH);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         left_ff      <= left_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_key_ff     <= rsp_key_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_empty_ff   <= rsp_empty_in;
      rsp_present_ff <= rsp_present_in;
   end

   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_key     = rsp_key_ff;
   assign rsp_tlast   = rsp_last_ff;
   assign rsp_empty   = rsp_empty_ff;
   assign rsp_present = rsp_present_ff;
   assign count       = count_ff;

endmodule

// ----- sv/mru_key_list.sv -----
// Top level of the MRU key list: a chain of key cells and its sequencer.
// Depends on mkl_pkg, mkl_cell and mkl_ctrl.
//
// A request carries a mode in req_tuser (insert, remove, clear, list) and a key in
// req_tdata. Insert moves the key to the front, removing an older copy and dropping
// the oldest entry when the list is full; remove deletes a stored copy; clear
// empties the list. Each of these returns one result in the cycle after the request,
// with tlast set and, for insert and remove, tuser[1] telling whether the key was
// already stored. A list request returns the stored keys most recent first, one per
// cycle while the receiver does not stall, the last one with tlast; with nothing
// stored it returns one result, in the cycle after the request, with tuser[0] set.
// Update requests are taken one per cycle while results drain; a list request holds
// the request side until its last entry is handed on, because the cell chain rotates
// by one cell for every key it hands to the result register.
// csr_wr_data sets the capacity (zero acts as one, above 16 acts as 16); writing a
// smaller capacity drops the oldest entries at once. Write it only while idle.
// Reset empties the list and sets the capacity to 16. When the receiver stalls, the
// result register holds its result and no new request is taken.

module mru_key_list
   import mkl_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [31:0]         req_tdata,   // [31:0] key
   input  logic [1:0]          req_tuser,   // [1:0] mode
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [31:0]         rsp_tdata,   // [31:0] entry_key
   output logic                rsp_tlast,
   output logic [1:0]          rsp_tuser,   // [0] list_empty, [1] was_present
   input  logic                csr_wr_en,
   input  logic [CAP_BITS-1:0] csr_wr_data
);

   cell_ctl_type cell_ctl;
   cnt_type      count;
   key_type      key_q [DEPTH];
   logic         hit [DEPTH+1];
   key_type      rsp_key;

   assign hit[0] = 1'b0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      key_type left_key;
      key_type right_key;

      if (i == 0) begin : g_head
         assign left_key = req_tdata;
      end else begin : g_body
         assign left_key = key_q[i-1];
      end

      if (i == DEPTH - 1) begin : g_end
         assign right_key = key_q[i];
      end else begin : g_mid
         assign right_key = key_q[i+1];
      end

      mkl_cell u_cell (
         .clock     (clock),
         .ctl       (cell_ctl),
         .occupied  (cnt_type'(i) < count),
         .tail      (cnt_type'(i + 1) == count),
         .left_key  (left_key),
         .right_key (right_key),
         .wrap_key  (key_q[0]),
         .hit_in    (hit[i]),
         .hit_out   (hit[i+1]),
         .key_q     (key_q[i])
      );
   end

   mkl_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_key     (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_key     (rsp_key),
      .rsp_tlast   (rsp_tlast),
      .rsp_empty   (rsp_tuser[0]),
      .rsp_present (rsp_tuser[1]),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .found       (hit[DEPTH]),
      .head_key    (key_q[0]),
      .cell_ctl    (cell_ctl),
      .count       (count)
   );

   assign rsp_tdata = rsp_key;

endmodule
